FILE: rtl/planar_pose_rezero_and_stop_detect_macros.svh
// Assertion macros for the planar pose re-zero and stop detect block.
`ifndef PLANAR_POSE_REZERO_AND_STOP_DETECT_MACROS_SVH
`define PLANAR_POSE_REZERO_AND_STOP_DETECT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define PPR_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PPR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: rtl/ppr_pkg.sv
// Shared constants, types and tables for the planar pose re-zero block.
`timescale 1ns / 1ps
package ppr_pkg;
    localparam int CordicSteps = 16;
    localparam int StepBits = $clog2(CordicSteps + 1);
    localparam int AccBits = 64;
    localparam logic [AccBits-1:0] InvGain = 64'd652032874;

    typedef enum logic [1:0] {
        OP_YAW = 2'd0,
        OP_ROT = 2'd1
    } op_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic       load;
        logic       init;
        logic       step;
        op_t        op;
        logic       gain;
        logic       gain_sel;
        logic       store_yaw;
        logic       apply_offset;
        logic       finish;
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic pending;
    } sts_t;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0: r = 32'h20000000;
                5'd1: r = 32'h12E4051E;
                5'd2: r = 32'h09FB385B;
                5'd3: r = 32'h051111D4;
                5'd4: r = 32'h028B0D43;
                5'd5: r = 32'h0145D7E1;
                5'd6: r = 32'h00A2F61E;
                5'd7: r = 32'h00517C55;
                5'd8: r = 32'h0028BE53;
                5'd9: r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98;
                5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6;
                5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2F9;
                5'd15: r = 32'h0000517C;
                5'd16: r = 32'h000028BE;
                5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A2F;
                5'd19: r = 32'h00000517;
                5'd20: r = 32'h0000028B;
                5'd21: r = 32'h00000145;
                5'd22: r = 32'h000000A2;
                5'd23: r = 32'h00000051;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction
endpackage

FILE: rtl/ppr_ctrl.sv
// Sequencer that walks one odometry item through yaw, rotations and output.
`timescale 1ns / 1ps
module ppr_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_kind,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  ppr_pkg::sts_t  sts,
    output ppr_pkg::cmd_t  cmd
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_YAWI, ST_YAW, ST_YAWD, ST_ROTI, ST_ROT, ST_GAINX, ST_GAINY,
        ST_DONE, ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic [ppr_pkg::StepBits-1:0] cnt_reg, cnt_next;
    logic zero_pass_reg, zero_pass_next;
    logic m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        zero_pass_next = zero_pass_reg;
        m_valid_next = m_valid_reg;
        cmd = '0;
        cmd.op = ppr_pkg::OP_YAW;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (!s_kind) state_next = ST_YAWI;
                end
            end
            ST_YAWI: begin
                cmd.init = 1'b1;
                cmd.op = ppr_pkg::OP_YAW;
                cnt_next = '0;
                state_next = ST_YAW;
            end
            ST_YAW: begin
                cmd.step = 1'b1;
                cmd.op = ppr_pkg::OP_YAW;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ppr_pkg::StepBits'(ppr_pkg::CordicSteps - 1))
                    state_next = ST_YAWD;
            end
            ST_YAWD: begin
                cmd.store_yaw = 1'b1;
                zero_pass_next = sts.pending;
                state_next = ST_ROTI;
            end
            ST_ROTI: begin
                cmd.init = 1'b1;
                cmd.op = ppr_pkg::OP_ROT;
                cmd.gain_sel = zero_pass_reg;
                cnt_next = '0;
                state_next = ST_ROT;
            end
            ST_ROT: begin
                cmd.step = 1'b1;
                cmd.op = ppr_pkg::OP_ROT;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ppr_pkg::StepBits'(ppr_pkg::CordicSteps - 1))
                    state_next = ST_GAINX;
            end
            ST_GAINX: begin
                cmd.gain = 1'b1;
                state_next = ST_GAINY;
            end
            ST_GAINY: begin
                cmd.gain = 1'b1;
                cmd.gain_sel = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (zero_pass_reg) begin
                    cmd.apply_offset = 1'b1;
                    zero_pass_next = 1'b0;
                    state_next = ST_ROTI;
                end else begin
                    cmd.finish = 1'b1;
                    m_valid_next = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            zero_pass_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            zero_pass_reg <= zero_pass_next;
            m_valid_reg <= m_valid_next;
        end
    end
endmodule

FILE: rtl/ppr_dp.sv
// Datapath: shared CORDIC, gain multiply, offset store and stop detector.
`timescale 1ns / 1ps
module ppr_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 s_kind,
    input  logic                 s_reset_level,
    input  logic signed [31:0]   s_pos_x,
    input  logic signed [31:0]   s_pos_y,
    input  logic signed [15:0]   s_quat_x,
    input  logic signed [15:0]   s_quat_y,
    input  logic signed [15:0]   s_quat_z,
    input  logic signed [15:0]   s_quat_w,
    input  logic signed [31:0]   s_forward_rate,
    input  logic signed [31:0]   s_yaw_rate,
    input  logic [47:0]          s_sample_time,
    input  ppr_pkg::cmd_t        cmd,
    output ppr_pkg::sts_t        sts,
    output logic signed [31:0]   m_corrected_x,
    output logic signed [31:0]   m_corrected_y,
    output logic signed [15:0]   m_corrected_yaw,
    output logic                 m_stopped,
    output logic                 m_stop_changed,
    output logic                 m_reset_done
);
    localparam int W = 40;

    logic [30:0] lin_thr_reg, ang_thr_reg;
    logic [31:0] hold_reg;
    logic pending_reg, run_active_reg, prev_stop_reg, reported_reg, done_reg;
    logic [47:0] run_start_reg;
    logic signed [31:0] off_x_reg, off_y_reg;
    logic [15:0] off_h_reg;

    logic signed [31:0] px_reg, py_reg, fr_reg, yr_reg;
    logic signed [15:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic [47:0] t_reg;
    logic [15:0] yaw_reg;

    logic signed [W-1:0] cx_reg, cy_reg;
    logic signed [33:0] cz_reg;
    logic neg_reg;
    logic [4:0] idx_reg;
    logic signed [31:0] gx_reg, gy_reg;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lin_thr_reg <= 31'd655;
            ang_thr_reg <= 31'd655;
            hold_reg <= 32'd10000;
        end else if (cfg_we) begin
            if (cfg_index == 2'd0) lin_thr_reg <= cfg_data[30:0];
            else if (cfg_index == 2'd1) ang_thr_reg <= cfg_data[30:0];
            else if (cfg_index == 2'd2) hold_reg <= cfg_data;
        end
    end

    assign sts.pending = pending_reg;

    // Quaternion products for the yaw vector.
    logic signed [33:0] qy_vec, qx_vec;
    always_comb begin
        qy_vec = 34'(2 * ($signed(34'(qw_reg * qz_reg)) + $signed(34'(qx_reg * qy_reg))));
        qx_vec = 34'sd268435456 - 34'(2 * ($signed(34'(qy_reg * qy_reg))
                 + $signed(34'(qz_reg * qz_reg))));
    end

    // Rotation angle setup and fold.
    logic [15:0] rot_ang;
    logic signed [33:0] z0;
    always_comb begin
        rot_ang = cmd.gain_sel ? 16'(16'd0 - yaw_reg) : off_h_reg;
        z0 = 34'($signed(rot_ang)) <<< 16;
    end

    // One CORDIC iteration.
    logic signed [W-1:0] dx, dy;
    logic signed [33:0] at;
    logic dir;
    always_comb begin
        dx = cy_reg >>> idx_reg;
        dy = cx_reg >>> idx_reg;
        at = 34'($signed({1'b0, ppr_pkg::atan_entry(idx_reg)}));
        dir = (cmd.op == ppr_pkg::OP_YAW) ? cy_reg[W-1] : !cz_reg[33];
    end

    // Gain multiply, split into a 20-bit low part and a high part.
    logic signed [W-1:0] gv;
    logic signed [W-21:0] vh;
    logic [19:0] vl;
    logic signed [63:0] a_h, a_l, gres;
    always_comb begin
        gv = cmd.gain_sel ? cy_reg : cx_reg;
        vh = gv[W-1:20];
        vl = gv[19:0];
        a_h = (64'(vh) * 64'sd652032874) <<< 20;
        a_l = $signed({44'd0, vl}) * 64'sd652032874;
        gres = (a_h + a_l + 64'sd536870912) >>> 30;
    end

    // Stop detection on the captured sample.
    logic [31:0] afr, ayr;
    logic below, run_act_n, stopped_n, prev_n;
    logic [47:0] start_n, diff;
    always_comb begin
        afr = fr_reg[31] ? 32'(-fr_reg) : 32'(fr_reg);
        ayr = yr_reg[31] ? 32'(-yr_reg) : 32'(yr_reg);
        below = (afr <= {1'b0, lin_thr_reg}) && (ayr <= {1'b0, ang_thr_reg});
        prev_n = done_reg ? 1'b0 : prev_stop_reg;
        run_act_n = done_reg ? 1'b0 : run_active_reg;
        start_n = run_start_reg;
        stopped_n = 1'b0;
        if (below) begin
            if (!run_act_n || t_reg < run_start_reg) start_n = t_reg;
            run_act_n = 1'b1;
            diff = t_reg - start_n;
            stopped_n = diff >= {16'd0, hold_reg};
        end else begin
            run_act_n = 1'b0;
            diff = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b0;
            off_x_reg <= '0;
            off_y_reg <= '0;
            off_h_reg <= '0;
            run_active_reg <= 1'b0;
            run_start_reg <= '0;
            prev_stop_reg <= 1'b0;
            reported_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                if (s_kind) pending_reg <= s_reset_level;
                done_reg <= 1'b0;
            end
            if (cmd.apply_offset) begin
                off_x_reg <= 32'(-gx_reg);
                off_y_reg <= 32'(-gy_reg);
                off_h_reg <= 16'(16'd0 - yaw_reg);
                pending_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            if (cmd.finish) begin
                run_active_reg <= run_act_n;
                run_start_reg <= start_n;
                prev_stop_reg <= stopped_n;
                reported_reg <= 1'b1;
            end
        end
    end

    // Sample capture, CORDIC and result registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            px_reg <= s_pos_x;
            py_reg <= s_pos_y;
            qx_reg <= s_quat_x;
            qy_reg <= s_quat_y;
            qz_reg <= s_quat_z;
            qw_reg <= s_quat_w;
            fr_reg <= s_forward_rate;
            yr_reg <= s_yaw_rate;
            t_reg <= s_sample_time;
        end
        if (cmd.init) begin
            idx_reg <= '0;
            if (cmd.op == ppr_pkg::OP_YAW) begin
                neg_reg <= 1'b0;
                if (qx_vec < 0) begin
                    if (qy_vec >= 0) begin
                        cx_reg <= W'(qy_vec);
                        cy_reg <= W'(-qx_vec);
                        cz_reg <= 34'sd1073741824;
                    end else begin
                        cx_reg <= W'(-qy_vec);
                        cy_reg <= W'(qx_vec);
                        cz_reg <= -34'sd1073741824;
                    end
                end else begin
                    cx_reg <= W'(qx_vec);
                    cy_reg <= W'(qy_vec);
                    cz_reg <= '0;
                end
            end else begin
                cx_reg <= W'(px_reg);
                cy_reg <= W'(py_reg);
                if (z0 > 34'sd1073741824) begin
                    cz_reg <= z0 - 34'sd2147483648;
                    neg_reg <= 1'b1;
                end else if (z0 < -34'sd1073741824) begin
                    cz_reg <= z0 + 34'sd2147483648;
                    neg_reg <= 1'b1;
                end else begin
                    cz_reg <= z0;
                    neg_reg <= 1'b0;
                end
            end
        end else if (cmd.step) begin
            idx_reg <= idx_reg + 5'd1;
            if (dir) begin
                cx_reg <= cx_reg - dx;
                cy_reg <= cy_reg + dy;
                cz_reg <= (cmd.op == ppr_pkg::OP_YAW) ? cz_reg - at : cz_reg - at;
            end else begin
                cx_reg <= cx_reg + dx;
                cy_reg <= cy_reg - dy;
                cz_reg <= cz_reg + at;
            end
        end
        if (cmd.store_yaw) yaw_reg <= 16'((cz_reg + 34'sd32768) >>> 16);
        if (cmd.gain) begin
            if (cmd.gain_sel) gy_reg <= neg_reg ? 32'(-gres) : 32'(gres);
            else gx_reg <= neg_reg ? 32'(-gres) : 32'(gres);
        end
        if (cmd.finish) begin
            m_corrected_x <= off_x_reg + gx_reg;
            m_corrected_y <= off_y_reg + gy_reg;
            m_corrected_yaw <= off_h_reg + yaw_reg;
            m_stopped <= stopped_n;
            m_stop_changed <= !reported_reg || (stopped_n != prev_n);
            m_reset_done <= done_reg;
        end
    end
endmodule

FILE: rtl/planar_pose_rezero_and_stop_detect.sv
// Top level: planar pose re-zero with stop detection.
// An odometry item runs yaw vectoring, one rotation pass and the gain multiply,
// plus a second CORDIC rotation pass when it re-zeroes the offset. A reset-request
// item is only registered. One item at a time on the shared 16-step CORDIC unit.
// Reset: synchronous active low aresetn clears state and loads threshold defaults.
`timescale 1ns / 1ps
`include "planar_pose_rezero_and_stop_detect_macros.svh"
module planar_pose_rezero_and_stop_detect (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_kind,
    input  logic                s_reset_level,
    input  logic signed [31:0]  s_pos_x,
    input  logic signed [31:0]  s_pos_y,
    input  logic signed [15:0]  s_quat_x,
    input  logic signed [15:0]  s_quat_y,
    input  logic signed [15:0]  s_quat_z,
    input  logic signed [15:0]  s_quat_w,
    input  logic signed [31:0]  s_forward_rate,
    input  logic signed [31:0]  s_yaw_rate,
    input  logic [47:0]         s_sample_time,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_corrected_x,
    output logic signed [31:0]  m_corrected_y,
    output logic signed [15:0]  m_corrected_yaw,
    output logic                m_stopped,
    output logic                m_stop_changed,
    output logic                m_reset_done
);
    ppr_pkg::cmd_t cmd;
    ppr_pkg::sts_t sts;

    ppr_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_kind(s_kind),
        .s_ready(s_ready), .m_valid(m_valid), .m_ready(m_ready), .sts(sts), .cmd(cmd)
    );

    ppr_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_kind(s_kind), .s_reset_level(s_reset_level),
        .s_pos_x(s_pos_x), .s_pos_y(s_pos_y), .s_quat_x(s_quat_x),
        .s_quat_y(s_quat_y), .s_quat_z(s_quat_z), .s_quat_w(s_quat_w),
        .s_forward_rate(s_forward_rate), .s_yaw_rate(s_yaw_rate),
        .s_sample_time(s_sample_time), .cmd(cmd), .sts(sts),
        .m_corrected_x(m_corrected_x), .m_corrected_y(m_corrected_y),
        .m_corrected_yaw(m_corrected_yaw), .m_stopped(m_stopped),
        .m_stop_changed(m_stop_changed), .m_reset_done(m_reset_done)
    );

    // The input side never takes an item while a result is waiting.
    `PPR_ASSERT_IMPL(a_no_overlap, aclk, aresetn, m_valid, !s_ready)
    // A fresh result follows a finish command.
    `PPR_ASSERT_NEXT(a_finish_valid, aclk, aresetn, cmd.finish, m_valid)
    // A stopped result after a re-zero always reports a stop change.
    `PPR_ASSERT_IMPL(a_done_changed, aclk, aresetn, m_valid && m_reset_done && m_stopped,
        m_stop_changed)
endmodule

FILE: sim/planar_pose_rezero_and_stop_detect_tb.sv
// Self-checking testbench for the planar pose re-zero and stop detect block.
`timescale 1ns / 1ps
module planar_pose_rezero_and_stop_detect_tb;
    localparam int RegLinThr = 0;
    localparam int RegAngThr = 1;
    localparam int RegHold = 2;
    localparam int RegSpare = 3;
    localparam logic KindOdom = 1'b0;
    localparam logic KindRezero = 1'b1;
    localparam int Steps = 16;
    localparam longint GainQ30 = 64'sd652032874;
    localparam int StallLimit = 5000;
    localparam int DrainCycles = 70;

    typedef struct {
        logic               kind;
        logic               level;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
        logic signed [31:0] fwd;
        logic signed [31:0] yawr;
        logic [47:0]        stamp;
    } odom_item_t;

    typedef struct {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [15:0] cyaw;
        logic               stopped;
        logic               changed;
        logic               rezeroed;
    } pose_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_corrected_x, m_corrected_y;
    logic signed [15:0] m_corrected_yaw;
    logic m_stopped, m_stop_changed, m_reset_done;

    odom_item_t cur = '{default: '0};
    odom_item_t pending_items[$];
    pose_result_t pose_expected[$];

    // Predictor state, mirrors the block after reset.
    logic [30:0] lin_thr = 31'd655;
    logic [30:0] ang_thr = 31'd655;
    logic [31:0] hold_us = 32'd10000;
    logic rezero_armed = 1'b0;
    longint off_x = 0;
    longint off_y = 0;
    logic [15:0] off_head = '0;
    logic run_on = 1'b0;
    logic [47:0] run_t0 = '0;
    logic last_stop = 1'b0;
    logic first_done = 1'b0;

    longint atan_lut[24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
        64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
        64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051};

    int acc_cnt = 0, offered = 0, gap = 0, results = 0, errors = 0;
    int rezero_seen = 0, stop_seen = 0, idle_cycles = 0;
    int hold_req = 0, hold_seen = 0, hold_left = 0, rx_gap = 0;
    logic quiet = 1'b0;
    logic [47:0] clock_us = 48'd1000;

    planar_pose_rezero_and_stop_detect dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_kind(cur.kind), .s_reset_level(cur.level),
        .s_pos_x(cur.px), .s_pos_y(cur.py),
        .s_quat_x(cur.qx), .s_quat_y(cur.qy), .s_quat_z(cur.qz), .s_quat_w(cur.qw),
        .s_forward_rate(cur.fwd), .s_yaw_rate(cur.yawr), .s_sample_time(cur.stamp),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_corrected_x(m_corrected_x), .m_corrected_y(m_corrected_y),
        .m_corrected_yaw(m_corrected_yaw), .m_stopped(m_stopped),
        .m_stop_changed(m_stop_changed), .m_reset_done(m_reset_done)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Multiply by the CORDIC inverse gain in Q30, split to stay inside 64 bits.
    function automatic longint gain_scale(input longint v);
        longint vh, vl, a, ah, al;
        vh = v >>> 20;
        vl = v - vh * (64'sd1 << 20);
        a = vh * GainQ30;
        ah = a >>> 10;
        al = a - ah * 1024;
        return ah + ((al * (64'sd1 << 20) + vl * GainQ30 + (64'sd1 << 29)) >>> 30);
    endfunction

    // Rotate a vector by a binary angle with rotation-mode CORDIC.
    function automatic void spin(inout longint x, inout longint y, input logic [15:0] ang);
        longint z, dx, dy;
        logic flip;
        z = longint'($signed(ang)) * 65536;
        flip = 1'b0;
        if (z > (64'sd1 << 30)) begin
            z -= 64'sd1 << 31;
            flip = 1'b1;
        end else if (z < -(64'sd1 << 30)) begin
            z += 64'sd1 << 31;
            flip = 1'b1;
        end
        for (int i = 0; i < Steps; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_lut[i];
            end else begin
                x += dx; y -= dy; z += atan_lut[i];
            end
        end
        x = gain_scale(x);
        y = gain_scale(y);
        if (flip) begin
            x = -x;
            y = -y;
        end
    endfunction

    // Heading of a quaternion as a binary angle, vectoring-mode CORDIC.
    function automatic logic [15:0] heading_of(input longint qx, qy, qz, qw);
        longint x, y, z, t, dx, dy;
        y = 2 * (qw * qz + qx * qy);
        x = (64'sd1 << 28) - 2 * (qy * qy + qz * qz);
        z = 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = 64'sd1 << 30;
            end else begin
                x = -y; y = t; z = -(64'sd1 << 30);
            end
        end
        for (int i = 0; i < Steps; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y < 0) begin
                x -= dx; y += dy; z -= atan_lut[i];
            end else begin
                x += dx; y -= dy; z += atan_lut[i];
            end
        end
        t = (z + 32768) >>> 16;
        return t[15:0];
    endfunction

    // Work out the result of one accepted item and update the predictor state.
    function automatic void predict_pose(input odom_item_t it);
        pose_result_t r;
        longint x, y;
        logic [15:0] hd;
        logic [32:0] afr, ayr;
        logic below, stp;
        if (it.kind == KindRezero) begin
            rezero_armed = it.level;
            return;
        end
        hd = heading_of(it.qx, it.qy, it.qz, it.qw);
        r.rezeroed = rezero_armed;
        if (rezero_armed) begin
            x = it.px;
            y = it.py;
            spin(x, y, 16'h0 - hd);
            off_x = longint'($signed(32'(-x)));
            off_y = longint'($signed(32'(-y)));
            off_head = 16'h0 - hd;
            rezero_armed = 1'b0;
            run_on = 1'b0;
            last_stop = 1'b0;
        end
        x = it.px;
        y = it.py;
        spin(x, y, off_head);
        r.cx = 32'(off_x + x);
        r.cy = 32'(off_y + y);
        r.cyaw = off_head + hd;
        afr = it.fwd < 0 ? -33'(it.fwd) : 33'(it.fwd);
        ayr = it.yawr < 0 ? -33'(it.yawr) : 33'(it.yawr);
        below = afr <= lin_thr && ayr <= ang_thr;
        if (below) begin
            if (!run_on || it.stamp < run_t0) begin
                run_on = 1'b1;
                run_t0 = it.stamp;
            end
            stp = (it.stamp - run_t0) >= 48'(hold_us);
        end else begin
            run_on = 1'b0;
            stp = 1'b0;
        end
        r.changed = first_done ? (stp != last_stop) : 1'b1;
        first_done = 1'b1;
        last_stop = stp;
        r.stopped = stp;
        pose_expected.push_back(r);
    endfunction

    // Input acceptance, result checking and the stall watchdog.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                acc_cnt <= acc_cnt + 1;
                predict_pose(cur);
            end
            if (m_valid && m_ready) begin
                if (pose_expected.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("ERROR: result with nothing expected");
                end else begin
                    pose_result_t e;
                    e = pose_expected.pop_front();
                    results++;
                    rezero_seen += m_reset_done;
                    stop_seen += m_stopped;
                    if (m_corrected_x !== e.cx || m_corrected_y !== e.cy ||
                        m_corrected_yaw !== e.cyaw || m_stopped !== e.stopped ||
                        m_stop_changed !== e.changed || m_reset_done !== e.rezeroed) begin
                        errors++;
                        if (errors <= 10)
                            $display("ERROR: result %0d exp x=%h y=%h yaw=%h st=%b ch=%b rz=%b got x=%h y=%h yaw=%h st=%b ch=%b rz=%b",
                                results, e.cx, e.cy, e.cyaw, e.stopped, e.changed,
                                e.rezeroed, m_corrected_x, m_corrected_y, m_corrected_yaw,
                                m_stopped, m_stop_changed, m_reset_done);
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= StallLimit) begin
                $display("ERROR: no handshake for %0d cycles", StallLimit);
                $display("planar_pose_rezero_and_stop_detect_tb NOT OK");
                $finish;
            end
        end
    end

    // Sender: offers queued items, with random idle bursts.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && acc_cnt != offered) begin
            // Item still waiting to be taken.
        end else if (gap > 0) begin
            gap <= gap - 1;
            s_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
            cur = pending_items.pop_front();
            s_valid <= 1'b1;
            offered <= offered + 1;
            if (!quiet && $urandom_range(0, 4) == 0) gap <= $urandom_range(1, 6);
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Receiver: random stall bursts plus one long hold-off on request.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= 400;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 4) == 0) rx_gap <= $urandom_range(1, 6);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == RegLinThr) lin_thr = val[30:0];
        else if (idx == RegAngThr) ang_thr = val[30:0];
        else if (idx == RegHold) hold_us = val;
    endtask

    // Wait until the block has delivered everything and is quiet.
    task automatic drain;
        while (pending_items.size() > 0 || s_valid || pose_expected.size() > 0)
            @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    function automatic logic signed [31:0] pick_rate(input logic still_run);
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0: v = 32'sh80000000;
            1, 2: v = $urandom;
            default: v = still_run ? $urandom_range(0, 1400) : $urandom_range(0, 70000);
        endcase
        if ($urandom_range(0, 1)) v = -v;
        return v;
    endfunction

    // Build one item; mostly odometry along a steady time line.
    function automatic odom_item_t make_item(input logic still_run);
        odom_item_t it;
        int sel;
        it.kind = ($urandom_range(0, 11) == 0) ? KindRezero : KindOdom;
        it.level = $urandom_range(0, 2) != 0;
        it.px = $urandom;
        it.py = $urandom;
        sel = $urandom_range(0, 3);
        if (sel == 0) begin
            it.qx = 0;
            it.qy = 0;
            it.qz = $urandom_range(0, 32768) - 16384;
            it.qw = $urandom_range(0, 32768) - 16384;
        end else begin
            it.qx = $urandom_range(0, 32768) - 16384;
            it.qy = $urandom_range(0, 32768) - 16384;
            it.qz = $urandom_range(0, 32768) - 16384;
            it.qw = $urandom_range(0, 32768) - 16384;
        end
        it.fwd = pick_rate(still_run);
        it.yawr = pick_rate(still_run);
        case ($urandom_range(0, 19))
            0: clock_us = clock_us - $urandom_range(0, 30000);
            1: clock_us = {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
            default: clock_us = clock_us + $urandom_range(0, 4000);
        endcase
        it.stamp = clock_us;
        return it;
    endfunction

    task automatic run_phase(input int n, input logic still_run);
        for (int i = 0; i < n; i++) pending_items.push_back(make_item(still_run));
    endtask

    function automatic odom_item_t odom(input logic signed [31:0] px, py,
                                        input logic signed [15:0] qz, qw,
                                        input logic signed [31:0] f, w,
                                        input logic [47:0] t);
        odom_item_t it;
        it = '{default: '0};
        it.kind = KindOdom;
        it.px = px; it.py = py; it.qz = qz; it.qw = qw;
        it.fwd = f; it.yawr = w; it.stamp = t;
        return it;
    endfunction

    initial begin
        odom_item_t it;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, re-zero, zero quaternion, backward stamp.
        pending_items.push_back(odom(32'sh7FFFFFFF, 32'sh80000000, 0, 16384, 0, 0, 0));
        pending_items.push_back(odom(32'sh80000000, 32'sh7FFFFFFF, 16384, 0, 655, -655, 5000));
        pending_items.push_back(odom(100, -200, 0, 0, 0, 0, 15000));
        pending_items.push_back(odom(1 << 16, 1 << 16, -16384, 0, 656, 0, 16000));
        pending_items.push_back(odom(5, 5, 11585, 11585, 32'sh80000000, 0, 17000));
        pending_items.push_back(odom(5, 5, -11585, -11585, 0, 32'sh80000000, 18000));
        it = odom(0, 0, 0, 0, 0, 0, 0);
        it.kind = KindRezero;
        it.level = 1'b1;
        it.px = -1; it.py = -1; it.qx = -16384; it.qy = 16384;
        it.fwd = -1; it.yawr = -1; it.stamp = '1;
        pending_items.push_back(it);
        pending_items.push_back(odom(32'sh12345678, -32'sh0ABCDEF0, 5000, 15000, 0, 0, 20000));
        pending_items.push_back(odom(32'sh12345678, -32'sh0ABCDEF0, 5000, 15000, 0, 0, 30000));
        pending_items.push_back(odom(7, 9, 0, 16384, 0, 0, 40001));
        pending_items.push_back(odom(7, 9, 0, 16384, 0, 0, 25000));
        pending_items.push_back(odom(7, 9, 0, 16384, 0, 0, 36000));
        it.level = 1'b1;
        pending_items.push_back(it);
        it.level = 1'b0;
        pending_items.push_back(it);
        it = odom(-3, 4, 16384, -16384, 0, 0, 48'hFFFF_FFFF_FFFF);
        it.level = 1'b1;
        it.qx = 16384; it.qy = -16384;
        pending_items.push_back(it);
        pending_items.push_back(odom(0, 0, 0, -16384, 700, 10, 48'hFFFF_FFFF_FFFF));
        drain();

        // Wide thresholds, longest hold.
        write_reg(RegLinThr, 32'hFFFFFFFF);
        write_reg(RegAngThr, 32'h7FFFFFFF);
        write_reg(RegHold, 32'hFFFFFFFF);
        write_reg(RegSpare, 32'h0);
        run_phase(300, 1'b1);
        drain();

        // Zero thresholds and no hold; the receiver holds off meanwhile.
        write_reg(RegLinThr, 32'h0);
        write_reg(RegAngThr, 32'h0);
        write_reg(RegHold, 32'h0);
        hold_req = hold_req + 1;
        run_phase(300, 1'b1);
        drain();

        write_reg(RegLinThr, 32'd1000);
        write_reg(RegAngThr, 32'd400);
        write_reg(RegHold, 32'd5000);
        write_reg(RegSpare, 32'hFFFFFFFF);
        run_phase(450, 1'b1);
        drain();

        write_reg(RegLinThr, 32'd655);
        write_reg(RegAngThr, 32'd655);
        write_reg(RegHold, 32'd10000);
        run_phase(300, 1'b0);
        run_phase(300, 1'b1);
        drain();

        // Last part runs without idling on either side.
        quiet = 1'b1;
        run_phase(280, 1'b1);
        drain();

        $display("Run checked %0d results over %0d items, %0d re-zeroes, %0d stopped.",
            results, acc_cnt, rezero_seen, stop_seen);
        $display("Threshold and hold settings covered zero, maximum and defaults.");
        if (errors == 0) begin
            $display("planar_pose_rezero_and_stop_detect_tb OK");
        end else begin
            $display("Mismatches: %0d", errors);
            $display("planar_pose_rezero_and_stop_detect_tb NOT OK");
        end
        $finish;
    end
endmodule

FILE: planar_pose_rezero_and_stop_detect.f
+incdir+rtl
rtl/ppr_pkg.sv
rtl/ppr_ctrl.sv
rtl/ppr_dp.sv
rtl/planar_pose_rezero_and_stop_detect.sv
sim/planar_pose_rezero_and_stop_detect_tb.sv
